// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the touch gesture classifier RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check, disabled while reset is asserted (active low reset)
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Clocked check that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== design/tgc_pkg.sv =====
// ----------------------------------------------------------------------------
// tgc_pkg
// Types, widths and constants of the touch gesture classifier.
// ----------------------------------------------------------------------------
package tgc_pkg;

    localparam int CoordW = 11;
    localparam int TimeW  = 32;
    localparam int ThrW   = 8;

    // Register map (word index)
    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    localparam logic [CoordW-1:0] WidthReset  = 11'd960;
    localparam logic [CoordW-1:0] HeightReset = 11'd540;

    // Classification limits
    localparam logic [TimeW-1:0]  LongPressMs = 32'd700;
    localparam logic [CoordW-1:0] TapSlopPx   = 11'd16;
    localparam logic [ThrW-1:0]   SwipeMinPx  = 8'd48;

    // floor(2n/25) as (2n * 5243) >> 17, exact for 2n < 4096
    localparam logic [12:0] ThrRecip = 13'd5243;
    localparam int          ThrShift = 17;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_PRESS   = 2'd1,
        MODE_HOLD    = 2'd2,
        MODE_RELEASE = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        GEST_NONE  = 3'd0,
        GEST_TAP   = 3'd1,
        GEST_LONG  = 3'd2,
        GEST_LEFT  = 3'd3,
        GEST_UP    = 3'd4,
        GEST_DOWN  = 3'd5
    } gesture_t;

    typedef struct packed {
        logic              active;
        logic [CoordW-1:0] start_x;
        logic [CoordW-1:0] start_y;
        logic [CoordW-1:0] latest_x;
        logic [CoordW-1:0] latest_y;
        logic [TimeW-1:0]  start_time;
    } touch_state_t;

endpackage

// ===== design/touch_gesture_classifier.sv =====
// Path of a sample: input register, classify logic, result register.
// Throughput: one sample per cycle while m_ready is high; a stalled result holds both stages.
// Each accepted sample gives exactly one result item.
// Reset (aresetn low, synchronous) empties both stages, clears the touch state
// and loads screen size 960 x 540.
// ----------------------------------------------------------------------------
// touch_gesture_classifier
// Classifies touch samples into tap, long press and left/up/down swipes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module touch_gesture_classifier (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // sample input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_mode,
    input  logic [tgc_pkg::CoordW-1:0]    s_touch_x,
    input  logic [tgc_pkg::CoordW-1:0]    s_touch_y,
    input  logic [tgc_pkg::TimeW-1:0]     s_now_ms,
    // result output
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_gesture,
    output logic [tgc_pkg::CoordW-1:0]    m_event_x,
    output logic [tgc_pkg::CoordW-1:0]    m_event_y
);

    logic [tgc_pkg::ThrW-1:0]   swipe_thr;

    logic                       in_vld_reg;
    tgc_pkg::mode_t             mode_reg;
    logic [tgc_pkg::CoordW-1:0] tx_reg;
    logic [tgc_pkg::CoordW-1:0] ty_reg;
    logic [tgc_pkg::TimeW-1:0]  now_reg;

    tgc_pkg::touch_state_t      state_reg;
    tgc_pkg::touch_state_t      state_next;

    tgc_pkg::gesture_t          gest_next;
    logic [tgc_pkg::CoordW-1:0] ex_next;
    logic [tgc_pkg::CoordW-1:0] ey_next;

    logic                       out_vld_reg;
    tgc_pkg::gesture_t          gest_reg;
    logic [tgc_pkg::CoordW-1:0] ex_reg;
    logic [tgc_pkg::CoordW-1:0] ey_reg;

    logic                       advance;
    logic                       in_take;

    tgc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .swipe_thr (swipe_thr)
    );

    // Handshake: item moves from input register to result register
    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;
    assign in_take = s_valid && s_ready;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (in_take) begin
            in_vld_reg <= 1'b1;
        end else if (advance) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            mode_reg <= tgc_pkg::mode_t'(s_mode);
            tx_reg   <= s_touch_x;
            ty_reg   <= s_touch_y;
            now_reg  <= s_now_ms;
        end
    end

    tgc_classify u_classify (
        .state      (state_reg),
        .mode       (mode_reg),
        .touch_x    (tx_reg),
        .touch_y    (ty_reg),
        .now_ms     (now_reg),
        .swipe_thr  (swipe_thr),
        .state_next (state_next),
        .gesture    (gest_next),
        .event_x    (ex_next),
        .event_y    (ey_next)
    );

    // Touch state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            gest_reg <= gest_next;
            ex_reg   <= ex_next;
            ey_reg   <= ey_next;
        end
    end

    assign m_valid   = out_vld_reg;
    assign m_gesture = gest_reg;
    assign m_event_x = ex_reg;
    assign m_event_y = ey_reg;

    // Checks
    `ASSERT_CLK(a_none_zero_coords, aclk, aresetn,
        (out_vld_reg && gest_reg == tgc_pkg::GEST_NONE) |-> (ex_reg == '0 && ey_reg == '0))
    `ASSERT_CLK(a_non_release_none, aclk, aresetn,
        (advance && mode_reg != tgc_pkg::MODE_RELEASE) |=> (gest_reg == tgc_pkg::GEST_NONE))
    `ASSERT_CLK(a_release_ends_touch, aclk, aresetn,
        (advance && mode_reg == tgc_pkg::MODE_RELEASE) |=> !state_reg.active)
    `ASSERT_CLK(a_gesture_needs_touch, aclk, aresetn,
        (advance && !state_reg.active) |=> (gest_reg == tgc_pkg::GEST_NONE))
    `ASSERT_ALWAYS(a_ready_when_empty, aclk,
        (!in_vld_reg) |-> s_ready)

endmodule

// ===== design/tgc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tgc_cfg_regs
// APB register file for screen size and the registered swipe threshold.
// ----------------------------------------------------------------------------
module tgc_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic [tgc_pkg::ThrW-1:0]      swipe_thr
);

    logic [tgc_pkg::CoordW-1:0] width_reg;
    logic [tgc_pkg::CoordW-1:0] height_reg;
    logic [tgc_pkg::ThrW-1:0]   thr_reg;
    logic [tgc_pkg::ThrW-1:0]   thr_next;
    logic [tgc_pkg::CoordW-1:0] shorter;
    logic [24:0]                thr_prod;
    logic [tgc_pkg::ThrW-1:0]   thr_quot;
    logic                       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    // Register writes; byte offset bits are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= tgc_pkg::WidthReset;
            height_reg <= tgc_pkg::HeightReset;
        end else if (wr_en) begin
            if (paddr[2] == tgc_pkg::REG_SCREEN_WIDTH) begin
                width_reg <= pwdata[tgc_pkg::CoordW-1:0];
            end else begin
                height_reg <= pwdata[tgc_pkg::CoordW-1:0];
            end
        end
    end

    // Read mux
    always_comb begin
        if (paddr[2] == tgc_pkg::REG_SCREEN_WIDTH) begin
            prdata = {21'd0, width_reg};
        end else begin
            prdata = {21'd0, height_reg};
        end
    end

    // Threshold = max(48, floor(min(w, h) * 8 / 100))
    always_comb begin
        shorter  = (width_reg < height_reg) ? width_reg : height_reg;
        thr_prod = {13'd0, shorter, 1'b0} * {12'd0, tgc_pkg::ThrRecip};
        thr_quot = thr_prod[tgc_pkg::ThrShift +: tgc_pkg::ThrW];
        thr_next = (thr_quot < tgc_pkg::SwipeMinPx) ? tgc_pkg::SwipeMinPx : thr_quot;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= tgc_pkg::SwipeMinPx;
        end else begin
            thr_reg <= thr_next;
        end
    end

    assign swipe_thr = thr_reg;

endmodule

// ===== design/tgc_classify.sv =====
// ----------------------------------------------------------------------------
// tgc_classify
// Touch state update and release classification for one sample.
// ----------------------------------------------------------------------------
module tgc_classify (
    input  tgc_pkg::touch_state_t         state,
    input  tgc_pkg::mode_t                mode,
    input  logic [tgc_pkg::CoordW-1:0]    touch_x,
    input  logic [tgc_pkg::CoordW-1:0]    touch_y,
    input  logic [tgc_pkg::TimeW-1:0]     now_ms,
    input  logic [tgc_pkg::ThrW-1:0]      swipe_thr,
    output tgc_pkg::touch_state_t         state_next,
    output tgc_pkg::gesture_t             gesture,
    output logic [tgc_pkg::CoordW-1:0]    event_x,
    output logic [tgc_pkg::CoordW-1:0]    event_y
);

    logic [tgc_pkg::CoordW:0]   dx;
    logic [tgc_pkg::CoordW:0]   dy;
    logic [tgc_pkg::CoordW-1:0] ax;
    logic [tgc_pkg::CoordW-1:0] ay;
    logic [tgc_pkg::CoordW-1:0] mx;
    logic [tgc_pkg::TimeW-1:0]  dur;
    logic [13:0]                ax4;
    logic [13:0]                ay4;
    logic [13:0]                ax5;
    logic [13:0]                ay5;
    logic                       small_move;
    logic                       is_long;
    logic                       horiz;
    logic                       vert;
    tgc_pkg::gesture_t          rel_gest;
    logic                       at_start;

    // Travel from start to latest point
    always_comb begin
        dx  = {1'b0, state.latest_x} - {1'b0, state.start_x};
        dy  = {1'b0, state.latest_y} - {1'b0, state.start_y};
        ax  = dx[tgc_pkg::CoordW] ? tgc_pkg::CoordW'(-dx) : dx[tgc_pkg::CoordW-1:0];
        ay  = dy[tgc_pkg::CoordW] ? tgc_pkg::CoordW'(-dy) : dy[tgc_pkg::CoordW-1:0];
        mx  = (ax > ay) ? ax : ay;
        dur = now_ms - state.start_time;
        ax4 = {1'b0, ax, 2'b00};
        ay4 = {1'b0, ay, 2'b00};
        ax5 = {1'b0, ax, 2'b00} + {3'd0, ax};
        ay5 = {1'b0, ay, 2'b00} + {3'd0, ay};
        small_move = (mx <= tgc_pkg::TapSlopPx);
        is_long    = (dur >= tgc_pkg::LongPressMs) && small_move;
        horiz      = (ax >= {3'd0, swipe_thr}) && (ax4 >= ay5);
        vert       = (ay >= {3'd0, swipe_thr}) && (ay4 >= ax5);
    end

    // Release priority: long press, horizontal, vertical, tap
    always_comb begin
        at_start = 1'b0;
        rel_gest = tgc_pkg::GEST_NONE;
        priority if (is_long) begin
            rel_gest = tgc_pkg::GEST_LONG;
            at_start = 1'b1;
        end else if (horiz) begin
            // right swipe is dropped
            rel_gest = dx[tgc_pkg::CoordW] ? tgc_pkg::GEST_LEFT : tgc_pkg::GEST_NONE;
        end else if (vert) begin
            rel_gest = dy[tgc_pkg::CoordW] ? tgc_pkg::GEST_UP : tgc_pkg::GEST_DOWN;
        end else if (small_move) begin
            rel_gest = tgc_pkg::GEST_TAP;
            at_start = 1'b1;
        end else begin
            rel_gest = tgc_pkg::GEST_NONE;
        end
    end

    // State update and result per mode
    always_comb begin
        state_next = state;
        gesture    = tgc_pkg::GEST_NONE;
        unique case (mode)
            tgc_pkg::MODE_PRESS: begin
                state_next.active     = 1'b1;
                state_next.start_x    = touch_x;
                state_next.start_y    = touch_y;
                state_next.latest_x   = touch_x;
                state_next.latest_y   = touch_y;
                state_next.start_time = now_ms;
            end
            tgc_pkg::MODE_HOLD: begin
                if (state.active) begin
                    state_next.latest_x = touch_x;
                    state_next.latest_y = touch_y;
                end
            end
            tgc_pkg::MODE_RELEASE: begin
                if (state.active) begin
                    state_next.active = 1'b0;
                    gesture           = rel_gest;
                end
            end
            default: begin
                state_next = state;
            end
        endcase
    end

    // No gesture reports the origin
    always_comb begin
        if (gesture == tgc_pkg::GEST_NONE) begin
            event_x = '0;
            event_y = '0;
        end else if (at_start) begin
            event_x = state.start_x;
            event_y = state.start_y;
        end else begin
            event_x = state.latest_x;
            event_y = state.latest_y;
        end
    end

endmodule
